// ===== src/ides_pkg.sv =====
// ----------------------------------------------------------------------------
// ides_pkg
// Types and constants shared by the icon directory entry selector: beat
// payloads, parse phases, status codes, register indexes and entry layout.
// ----------------------------------------------------------------------------
package ides_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        image_is_png;
        logic [31:0] image_offset;
        logic [8:0]  icon_width;
        logic [8:0]  icon_height;
        logic [15:0] bit_depth;
    } result_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ENTRIES = 3'd1,
        PH_SKIP    = 3'd2,
        PH_MAGIC   = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [1:0] STATUS_BAD_OFFSET = 2'd2;
    localparam logic [1:0] STATUS_EARLY_END  = 2'd3;

    localparam logic [1:0] CFG_PREF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PREF_HEIGHT = 2'd1;

    localparam logic [15:0] TYPE_ICON   = 16'd1;
    localparam logic [15:0] TYPE_CURSOR = 16'd2;

    // Header is 6 bytes; the type word starts at byte 2, the count at byte 4.
    localparam logic [31:0] HEADER_LAST = 32'd5;
    localparam logic [3:0]  HEADER_LEN  = 4'd6;

    // Byte slots inside one 16-byte directory entry.
    localparam logic [3:0] EF_WIDTH    = 4'd0;
    localparam logic [3:0] EF_HEIGHT   = 4'd1;
    localparam logic [3:0] EF_COLOURS  = 4'd2;
    localparam logic [3:0] EF_DEPTH_LO = 4'd6;
    localparam logic [3:0] EF_DEPTH_HI = 4'd7;
    localparam logic [3:0] EF_LAST     = 4'd15;

    localparam logic [31:0] MAX_OFFSET = 32'hFFFF_FFFB;
    localparam logic [1:0]  MAGIC_LAST = 2'd3;

    function automatic logic [7:0] png_magic(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h89;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h4E;
            default: b = 8'h47;
        endcase
        return b;
    endfunction

endpackage

// ===== src/icon_directory_entry_selector_top.sv =====
// ----------------------------------------------------------------------------
// icon_directory_entry_selector_top
// Parses an icon or cursor file byte stream, keeps the best directory entry,
// checks its offset and tests the image for the PNG signature.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input stalls only while a result beat
// is held by result_stall.
// A result beat is registered from the byte that completes it.
// All per-byte work is a short step between the byte and the state registers;
// entry areas are formed by a registered 9x9 multiplier ahead of their use.
// Reset (rst_n low, asynchronous) clears the parse state and the preferred
// size registers; the last byte of a file returns the parse state to reset.
module icon_directory_entry_selector_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ides_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output ides_pkg::result_t   result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data
);

    // Configuration and derived area.
    logic [8:0]  pref_width_reg;
    logic [8:0]  pref_height_reg;
    logic [17:0] pref_area_reg;

    // Stream state.
    ides_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] entry_total_reg, entry_total_next;
    logic [15:0] entries_seen_reg, entries_seen_next;
    logic [31:0] field_reg, field_next;
    logic [8:0]  cur_width_reg, cur_width_next;
    logic [8:0]  cur_height_reg, cur_height_next;
    logic [7:0]  cur_colours_reg, cur_colours_next;
    logic [15:0] cur_depth_reg, cur_depth_next;
    logic [17:0] cur_area_reg;
    logic [8:0]  best_width_reg, best_width_next;
    logic [8:0]  best_height_reg, best_height_next;
    logic [15:0] best_depth_reg, best_depth_next;
    logic [31:0] best_offset_reg, best_offset_next;
    logic [17:0] best_area_reg, best_area_next;
    logic        magic_ok_reg, magic_ok_next;

    logic                result_valid_reg;
    ides_pkg::result_t   result_reg, result_next;
    logic                result_hit;

    logic        item_fire;
    logic [7:0]  b;
    logic [31:0] pos_inc;
    logic [3:0]  slot;
    logic [1:0]  lane;

    logic [15:0] hdr_type;
    logic [15:0] hdr_count;
    logic        header_bad;

    logic [7:0]  colours_m1;
    logic [15:0] derived_len;
    logic [15:0] depth_eff;
    logic        same_size;
    logic        has_pref;
    logic        cur_is_pref;
    logic        best_is_pref;
    logic        cur_better;
    logic        take_entry;
    logic [31:0] entry_offset;
    logic [31:0] offset_sel;
    logic [15:0] seen_inc;
    logic        all_seen;
    logic        offset_bad;
    logic        offset_at_end;

    logic [1:0]  magic_idx;
    logic        magic_match;

    assign item_fire    = item_valid && !item_stall;
    assign item_stall   = result_valid_reg && result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign b       = item.data_byte;
    assign pos_inc = pos_reg + 32'd1;
    assign slot    = pos_reg[3:0] - ides_pkg::HEADER_LEN;
    assign lane    = (phase_reg == ides_pkg::PH_HEADER) ? (pos_reg[1:0] + 2'd2) : slot[1:0];

    // Header words: type from bytes 2..3, count from byte 4 and this byte.
    assign hdr_type   = field_reg[15:0];
    assign hdr_count  = {b, field_reg[23:16]};
    assign header_bad = ((hdr_type != ides_pkg::TYPE_ICON) &&
                         (hdr_type != ides_pkg::TYPE_CURSOR)) || (hdr_count == 16'd0);

    // A zero bit count with a nonzero colour count is replaced by the bit length of (colours - 1).
    assign colours_m1 = cur_colours_reg - 8'd1;
    always_comb
    begin
        derived_len = 16'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (colours_m1[i])
            begin
                derived_len = 16'(i + 1);
            end
        end
    end
    assign depth_eff = ((cur_depth_reg == 16'd0) && (cur_colours_reg != 8'd0)) ?
                       derived_len : cur_depth_reg;

    assign same_size    = (cur_width_reg == best_width_reg) &&
                          (cur_height_reg == best_height_reg);
    assign has_pref     = (pref_width_reg != 9'd0) && (pref_height_reg != 9'd0);
    assign cur_is_pref  = (cur_width_reg == pref_width_reg) &&
                          (cur_height_reg == pref_height_reg);
    assign best_is_pref = (best_width_reg == pref_width_reg) &&
                          (best_height_reg == pref_height_reg);

    always_comb
    begin
        if (!same_size && has_pref && cur_is_pref)
        begin
            cur_better = 1'b1;
        end
        else if (!same_size && has_pref && best_is_pref)
        begin
            cur_better = 1'b0;
        end
        else if (!same_size && has_pref && (cur_area_reg != best_area_reg))
        begin
            cur_better = (cur_area_reg < best_area_reg) && (cur_area_reg >= pref_area_reg);
        end
        else if (cur_area_reg != best_area_reg)
        begin
            cur_better = cur_area_reg > best_area_reg;
        end
        else
        begin
            cur_better = depth_eff > best_depth_reg;
        end
    end

    assign take_entry    = (entries_seen_reg == 16'd0) || cur_better;
    assign entry_offset  = {b, field_reg[23:0]};
    assign offset_sel    = take_entry ? entry_offset : best_offset_reg;
    assign seen_inc      = entries_seen_reg + 16'd1;
    assign all_seen      = seen_inc == entry_total_reg;
    assign offset_bad    = (offset_sel < pos_inc) || (offset_sel > ides_pkg::MAX_OFFSET);
    assign offset_at_end = offset_sel == pos_inc;

    assign magic_idx   = pos_reg[1:0] - best_offset_reg[1:0];
    assign magic_match = b == ides_pkg::png_magic(magic_idx);

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            ides_pkg::PH_HEADER:
            begin
                if (pos_reg == ides_pkg::HEADER_LAST)
                begin
                    phase_next = header_bad ? ides_pkg::PH_DONE : ides_pkg::PH_ENTRIES;
                end
            end
            ides_pkg::PH_ENTRIES:
            begin
                if ((slot == ides_pkg::EF_LAST) && all_seen)
                begin
                    if (offset_bad)
                    begin
                        phase_next = ides_pkg::PH_DONE;
                    end
                    else if (offset_at_end)
                    begin
                        phase_next = ides_pkg::PH_MAGIC;
                    end
                    else
                    begin
                        phase_next = ides_pkg::PH_SKIP;
                    end
                end
            end
            ides_pkg::PH_SKIP:
            begin
                if (pos_inc == best_offset_reg)
                begin
                    phase_next = ides_pkg::PH_MAGIC;
                end
            end
            ides_pkg::PH_MAGIC:
            begin
                if (magic_idx == ides_pkg::MAGIC_LAST)
                begin
                    phase_next = ides_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        if (item.last_byte)
        begin
            phase_next = ides_pkg::PH_HEADER;
        end
    end

    // Datapath and result.
    always_comb
    begin
        pos_next          = (phase_reg != ides_pkg::PH_DONE) ? pos_inc : pos_reg;
        entry_total_next  = entry_total_reg;
        entries_seen_next = entries_seen_reg;
        field_next        = field_reg;
        cur_width_next    = cur_width_reg;
        cur_height_next   = cur_height_reg;
        cur_colours_next  = cur_colours_reg;
        cur_depth_next    = cur_depth_reg;
        best_width_next   = best_width_reg;
        best_height_next  = best_height_reg;
        best_depth_next   = best_depth_reg;
        best_offset_next  = best_offset_reg;
        best_area_next    = best_area_reg;
        magic_ok_next     = magic_ok_reg;
        result_hit        = 1'b0;
        result_next       = '0;

        case (phase_reg)
            ides_pkg::PH_HEADER:
            begin
                field_next[8*lane +: 8] = b;
                if ((pos_reg == ides_pkg::HEADER_LAST) && header_bad)
                begin
                    result_hit         = 1'b1;
                    result_next.status = ides_pkg::STATUS_BAD_HEADER;
                end
                else if (pos_reg == ides_pkg::HEADER_LAST)
                begin
                    entry_total_next  = hdr_count;
                    entries_seen_next = 16'd0;
                end
            end
            ides_pkg::PH_ENTRIES:
            begin
                if (slot[3:2] == 2'b11)
                begin
                    field_next[8*lane +: 8] = b;
                end
                if (slot == ides_pkg::EF_WIDTH)
                begin
                    cur_width_next = (b == 8'd0) ? 9'd256 : {1'b0, b};
                end
                if (slot == ides_pkg::EF_HEIGHT)
                begin
                    cur_height_next = (b == 8'd0) ? 9'd256 : {1'b0, b};
                end
                if (slot == ides_pkg::EF_COLOURS)
                begin
                    cur_colours_next = b;
                end
                if (slot == ides_pkg::EF_DEPTH_LO)
                begin
                    cur_depth_next[7:0] = b;
                end
                if (slot == ides_pkg::EF_DEPTH_HI)
                begin
                    cur_depth_next[15:8] = b;
                end
                if (slot == ides_pkg::EF_LAST)
                begin
                    cur_depth_next    = depth_eff;
                    entries_seen_next = seen_inc;
                    if (take_entry)
                    begin
                        best_width_next  = cur_width_reg;
                        best_height_next = cur_height_reg;
                        best_depth_next  = depth_eff;
                        best_offset_next = entry_offset;
                        best_area_next   = cur_area_reg;
                    end
                    if (all_seen && offset_bad)
                    begin
                        result_hit               = 1'b1;
                        result_next.status       = ides_pkg::STATUS_BAD_OFFSET;
                        result_next.image_offset = best_offset_next;
                        result_next.icon_width   = best_width_next;
                        result_next.icon_height  = best_height_next;
                        result_next.bit_depth    = best_depth_next;
                    end
                    else if (all_seen && offset_at_end)
                    begin
                        magic_ok_next = 1'b1;
                    end
                end
            end
            ides_pkg::PH_SKIP:
            begin
                if (pos_inc == best_offset_reg)
                begin
                    magic_ok_next = 1'b1;
                end
            end
            ides_pkg::PH_MAGIC:
            begin
                magic_ok_next = magic_ok_reg && magic_match;
                if (magic_idx == ides_pkg::MAGIC_LAST)
                begin
                    result_hit               = 1'b1;
                    result_next.status       = ides_pkg::STATUS_FOUND;
                    result_next.image_is_png = magic_ok_next;
                    result_next.image_offset = best_offset_reg;
                    result_next.icon_width   = best_width_reg;
                    result_next.icon_height  = best_height_reg;
                    result_next.bit_depth    = best_depth_reg;
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        // The final byte ends the file: report an early end if nothing was
        // reported yet, then return the stream state, but for the field register, to its reset values.
        if (item.last_byte)
        begin
            if (!result_hit && (phase_reg != ides_pkg::PH_DONE))
            begin
                result_hit         = 1'b1;
                result_next        = '0;
                result_next.status = ides_pkg::STATUS_EARLY_END;
            end
            pos_next          = 32'd0;
            entry_total_next  = 16'd0;
            entries_seen_next = 16'd0;
            cur_width_next    = 9'd0;
            cur_height_next   = 9'd0;
            cur_colours_next  = 8'd0;
            cur_depth_next    = 16'd0;
            best_width_next   = 9'd0;
            best_height_next  = 9'd0;
            best_depth_next   = 16'd0;
            best_offset_next  = 32'd0;
            best_area_next    = 18'd0;
            magic_ok_next     = 1'b1;
        end
    end

    // Configuration registers; the preferred area is registered from them and follows in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_width_reg  <= 9'd0;
            pref_height_reg <= 9'd0;
            pref_area_reg   <= 18'd0;
        end
        else
        begin
            if (cfg_we && (cfg_index == ides_pkg::CFG_PREF_WIDTH))
            begin
                pref_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == ides_pkg::CFG_PREF_HEIGHT))
            begin
                pref_height_reg <= cfg_data;
            end
            pref_area_reg <= pref_width_reg * pref_height_reg;
        end
    end

    // Area of the entry being read; width and height settle long before use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_area_reg <= 18'd0;
        end
        else
        begin
            cur_area_reg <= cur_width_reg * cur_height_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ides_pkg::PH_HEADER;
            pos_reg          <= 32'd0;
            entry_total_reg  <= 16'd0;
            entries_seen_reg <= 16'd0;
            field_reg        <= 32'd0;
            cur_width_reg    <= 9'd0;
            cur_height_reg   <= 9'd0;
            cur_colours_reg  <= 8'd0;
            cur_depth_reg    <= 16'd0;
            best_width_reg   <= 9'd0;
            best_height_reg  <= 9'd0;
            best_depth_reg   <= 16'd0;
            best_offset_reg  <= 32'd0;
            best_area_reg    <= 18'd0;
            magic_ok_reg     <= 1'b1;
        end
        else if (item_fire)
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            entry_total_reg  <= entry_total_next;
            entries_seen_reg <= entries_seen_next;
            field_reg        <= field_next;
            cur_width_reg    <= cur_width_next;
            cur_height_reg   <= cur_height_next;
            cur_colours_reg  <= cur_colours_next;
            cur_depth_reg    <= cur_depth_next;
            best_width_reg   <= best_width_next;
            best_height_reg  <= best_height_next;
            best_depth_reg   <= best_depth_next;
            best_offset_reg  <= best_offset_next;
            best_area_reg    <= best_area_next;
            magic_ok_reg     <= magic_ok_next;
        end
    end

    // Result beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_fire && result_hit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && result_hit)
        begin
            result_reg <= result_next;
        end
    end

endmodule
